// File: src/tsc_pkg.sv
// Package for the time scale converter: payload types, scale and status codes,
// leap-second tables and the sign-magnitude add and dAT lookup functions.
// No dependencies.
package tsc_pkg;

   localparam int MagW = 63;

   localparam logic [3:0] ScaleUtc = 4'd0;
   localparam logic [3:0] ScaleTt  = 4'd1;
   localparam logic [3:0] ScaleTai = 4'd2;
   localparam logic [3:0] ScaleGps = 4'd3;

   localparam logic [1:0] StatOk          = 2'd0;
   localparam logic [1:0] StatUnsupported = 2'd1;
   localparam logic [1:0] StatTableMiss   = 2'd2;
   localparam logic [1:0] StatOverflow    = 2'd3;

   localparam logic [MagW-1:0] MagMax   = {MagW{1'b1}};
   localparam logic [MagW-1:0] TtTaiNs  = 63'd32184000000;
   localparam logic [MagW-1:0] TaiGpsNs = 63'd19000000000;
   localparam logic [MagW-1:0] SecNs    = 63'd1000000000;

   localparam logic [MagW-1:0] UtcPostStep [5] = '{
      63'd536500800000000000, 63'd488980800000000000, 63'd394372800000000000,
      63'd284040000000000000, 63'd189345600000000000
   };
   localparam logic [MagW-1:0] TaiPostStep [5] = '{
      63'd536500836000000000, 63'd488980835000000000, 63'd394372834000000000,
      63'd284040033000000000, 63'd189345632000000000
   };
   // Pre-epoch points above zero, increasing in magnitude.
   localparam logic [MagW-1:0] UtcPrePt [14] = '{
      63'd31579200000000000,  63'd79012800000000000,  63'd126273600000000000,
      63'd173707200000000000, 63'd205243200000000000, 63'd236779200000000000,
      63'd284040000000000000, 63'd315576000000000000, 63'd378734400000000000,
      63'd457704000000000000, 63'd520862400000000000, 63'd552398400000000000,
      63'd583934400000000000, 63'd631195200000000000
   };
   localparam logic [MagW-1:0] TaiPrePt [14] = '{
      63'd31579169000000000,  63'd79012770000000000,  63'd126273571000000000,
      63'd173707172000000000, 63'd205243173000000000, 63'd236779174000000000,
      63'd284039975000000000, 63'd315575976000000000, 63'd378734377000000000,
      63'd457703978000000000, 63'd520862379000000000, 63'd552398380000000000,
      63'd583934381000000000, 63'd631195182000000000
   };

   typedef struct packed {
      logic [MagW-1:0] mag;
      logic            post;
      logic            ovf;
   } sm_type;

   typedef struct packed {
      logic            miss;
      logic [MagW-1:0] dat_ns;
   } dat_type;

   typedef struct packed {
      logic [MagW-1:0] mag;
      logic            post;
      logic [3:0]      src;
      logic [3:0]      dst;
      logic [1:0]      status;
      logic            done;
      logic [MagW-1:0] dat_ns;
   } pipe_type;

   // Signed add of an offset; saturate on magnitude overflow, flip side on zero crossing.
   function automatic sm_type sm_add(logic [MagW-1:0] mag, logic post,
                                     logic [MagW-1:0] d, logic d_pos);
      logic [MagW:0] sum;
      logic [MagW:0] diff;
      sm_type        r;
      sum   = {1'b0, mag} + {1'b0, d};
      diff  = {1'b0, mag} - {1'b0, d};
      r.ovf = 1'b0;
      if (post == d_pos) begin
         r.post = post;
         if (sum[MagW]) begin
            r.mag = MagMax;
            r.ovf = 1'b1;
         end else begin
            r.mag = sum[MagW-1:0];
         end
      end else if (!diff[MagW]) begin
         r.mag  = diff[MagW-1:0];
         r.post = post;
      end else begin
         r.mag  = d - mag;
         r.post = !post;
      end
      if (r.mag == '0) r.post = 1'b1;
      return r;
   endfunction

   // dAT from a table pair; the point counts set the offset in whole seconds.
   function automatic dat_type dat_lookup(logic [MagW-1:0] mag, logic post,
                                          logic use_tai);
      logic [3:0] cnt;
      logic [5:0] dat_s;
      dat_type    r;
      cnt = 4'd0;
      if (post) begin
         for (int i = 0; i < 5; i++) begin
            cnt = cnt + 4'((use_tai ? mag >= TaiPostStep[i] : mag >= UtcPostStep[i]));
         end
         dat_s  = 6'd32 + {2'b00, cnt};
         r.miss = 1'b0;
      end else begin
         for (int i = 0; i < 14; i++) begin
            cnt = cnt + 4'((use_tai ? mag > TaiPrePt[i] : mag > UtcPrePt[i]));
         end
         dat_s  = 6'd32 - {2'b00, cnt};
         r.miss = (cnt == 4'd14);
      end
      r.dat_ns = MagW'({57'd0, dat_s} * SecNs);
      return r;
   endfunction

endpackage

// File: src/time_scale_converter.sv
// Time scale converter top level: six-stage pipeline from UTC/TT/TAI/GPS
// to UTC/TT/TAI/GPS through TT. Depends on tsc_pkg.
//
// One sm_add or one table compare per stage. Throughput: one word per cycle;
// a stall on rsp freezes every stage together. Reset (synchronous) clears all
// stage valid bits.
module time_scale_converter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [tsc_pkg::MagW-1:0]  req_magnitude_ns,
   input  logic                      req_after_epoch,
   input  logic [3:0]                req_source_scale,
   input  logic [3:0]                req_target_scale,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [tsc_pkg::MagW-1:0]  rsp_result_magnitude_ns,
   output logic                      rsp_result_after_epoch,
   output logic [1:0]                rsp_status
);
   import tsc_pkg::*;

   localparam int Stages = 6;

   logic                    adv;
   logic [Stages-1:0]       vld_ff;
   pipe_type                st_ff [Stages];
   pipe_type                st_in [Stages];

   assign adv       = !vld_ff[Stages-1] || rsp_ready;
   assign req_ready = adv;

   // Stage 0: check scales, normalize zero, UTC source lookup.
   always_comb begin
      dat_type d;
      st_in[0].mag    = req_magnitude_ns;
      st_in[0].post   = req_after_epoch || (req_magnitude_ns == '0);
      st_in[0].src    = req_source_scale;
      st_in[0].dst    = req_target_scale;
      st_in[0].status = StatOk;
      st_in[0].done   = 1'b0;
      d = dat_lookup(st_in[0].mag, st_in[0].post, 1'b0);
      st_in[0].dat_ns = d.dat_ns;
      if (req_source_scale > ScaleGps || req_target_scale > ScaleGps) begin
         st_in[0].status = StatUnsupported;
         st_in[0].done   = 1'b1;
      end else if (req_source_scale == ScaleUtc && d.miss) begin
         st_in[0].status = StatTableMiss;
         st_in[0].done   = 1'b1;
      end
      if (st_in[0].done) begin
         st_in[0].mag  = '0;
         st_in[0].post = 1'b1;
      end
   end

   // Stage 1: add dAT or the GPS offset toward TAI.
   always_comb begin
      sm_type r;
      st_in[1] = st_ff[0];
      r = sm_add(st_ff[0].mag, st_ff[0].post,
                 (st_ff[0].src == ScaleUtc) ? st_ff[0].dat_ns : TaiGpsNs, 1'b1);
      if (!st_ff[0].done && (st_ff[0].src == ScaleUtc || st_ff[0].src == ScaleGps)) begin
         st_in[1].mag  = r.mag;
         st_in[1].post = r.post;
         if (r.ovf) st_in[1].status = StatOverflow;
      end
   end

   // Stage 2: TAI to TT.
   always_comb begin
      sm_type r;
      st_in[2] = st_ff[1];
      r = sm_add(st_ff[1].mag, st_ff[1].post, TtTaiNs, 1'b1);
      if (!st_ff[1].done && st_ff[1].src != ScaleTt) begin
         st_in[2].mag  = r.mag;
         st_in[2].post = r.post;
         if (r.ovf) st_in[2].status = StatOverflow;
      end
   end

   // Stage 3: TT to TAI.
   always_comb begin
      sm_type r;
      st_in[3] = st_ff[2];
      r = sm_add(st_ff[2].mag, st_ff[2].post, TtTaiNs, 1'b0);
      if (!st_ff[2].done && st_ff[2].dst != ScaleTt) begin
         st_in[3].mag  = r.mag;
         st_in[3].post = r.post;
         if (r.ovf) st_in[3].status = StatOverflow;
      end
   end

   // Stage 4: TAI-argument lookup for a UTC target; a miss overrides overflow.
   always_comb begin
      dat_type d;
      st_in[4] = st_ff[3];
      d = dat_lookup(st_ff[3].mag, st_ff[3].post, 1'b1);
      st_in[4].dat_ns = d.dat_ns;
      if (!st_ff[3].done && st_ff[3].dst == ScaleUtc && d.miss) begin
         st_in[4].status = StatTableMiss;
         st_in[4].done   = 1'b1;
         st_in[4].mag    = '0;
         st_in[4].post   = 1'b1;
      end
   end

   // Stage 5: subtract dAT or the GPS offset.
   always_comb begin
      sm_type r;
      st_in[5] = st_ff[4];
      r = sm_add(st_ff[4].mag, st_ff[4].post,
                 (st_ff[4].dst == ScaleUtc) ? st_ff[4].dat_ns : TaiGpsNs, 1'b0);
      if (!st_ff[4].done && (st_ff[4].dst == ScaleUtc || st_ff[4].dst == ScaleGps)) begin
         st_in[5].mag  = r.mag;
         st_in[5].post = r.post;
         if (r.ovf) st_in[5].status = StatOverflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Stages-2:0], req_valid};
      end
   end

   // Hold every stage while the output word is stalled.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Stages; i++) st_ff[i] <= st_in[i];
      end
   end

   assign rsp_valid               = vld_ff[Stages-1];
   assign rsp_result_magnitude_ns = st_ff[Stages-1].mag;
   assign rsp_result_after_epoch  = st_ff[Stages-1].post;
   assign rsp_status              = st_ff[Stages-1].status;

endmodule

// File: src/tsc_checker.sv
// Port-level checker for time_scale_converter, bound to the top level.
// Depends on tsc_pkg for status codes.
module tsc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [tsc_pkg::MagW-1:0] rsp_result_magnitude_ns,
   input logic                     rsp_result_after_epoch,
   input logic [1:0]               rsp_status
);
   import tsc_pkg::*;

   // Error words carry the epoch with the after flag set.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == StatUnsupported || rsp_status == StatTableMiss)
      |-> rsp_result_magnitude_ns == '0 && rsp_result_after_epoch)
      else $error("error word without zero result");

   a_zero_post: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_magnitude_ns == '0 |-> rsp_result_after_epoch)
      else $error("zero result before epoch");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken during output stall");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_magnitude_ns)
         && $stable(rsp_status))
      else $error("stalled output word changed");

endmodule

bind time_scale_converter tsc_checker u_tsc_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_ready               (req_ready),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_result_magnitude_ns (rsp_result_magnitude_ns),
   .rsp_result_after_epoch  (rsp_result_after_epoch),
   .rsp_status              (rsp_status)
);

// File: sim/conversion_scoreboard.sv
// Expected-result bookkeeping for the time scale converter test: leap-second
// tables, an independent conversion predictor and the response checker.
// Depends on tsc_pkg for the scale and status codes and the magnitude limit.
package conversion_check_pkg;
   import tsc_pkg::*;

   localparam logic [3:0] ScaleFirstUnused = 4'd4;
   localparam logic [3:0] ScaleLastCode    = 4'd15;

   localparam bit [62:0] TaiToTtNs   = 63'd32184000000;
   localparam bit [62:0] GpsToTaiNs  = 63'd19000000000;
   localparam bit [62:0] NsPerSecond = 63'd1000000000;

   // Newest step first; after the epoch a step is an inclusive lower bound.
   localparam bit [62:0] LeapUtcSteps [5] = '{
      63'd536500800000000000, 63'd488980800000000000, 63'd394372800000000000,
      63'd284040000000000000, 63'd189345600000000000
   };
   localparam bit [62:0] LeapTaiSteps [5] = '{
      63'd536500836000000000, 63'd488980835000000000, 63'd394372834000000000,
      63'd284040033000000000, 63'd189345632000000000
   };
   // Before the epoch, interval i is (pre[i], pre[i+1]] in magnitude.
   localparam bit [62:0] LeapUtcPre [15] = '{
      63'd0,                  63'd31579200000000000,  63'd79012800000000000,
      63'd126273600000000000, 63'd173707200000000000, 63'd205243200000000000,
      63'd236779200000000000, 63'd284040000000000000, 63'd315576000000000000,
      63'd378734400000000000, 63'd457704000000000000, 63'd520862400000000000,
      63'd552398400000000000, 63'd583934400000000000, 63'd631195200000000000
   };
   localparam bit [62:0] LeapTaiPre [15] = '{
      63'd0,                  63'd31579169000000000,  63'd79012770000000000,
      63'd126273571000000000, 63'd173707172000000000, 63'd205243173000000000,
      63'd236779174000000000, 63'd284039975000000000, 63'd315575976000000000,
      63'd378734377000000000, 63'd457703978000000000, 63'd520862379000000000,
      63'd552398380000000000, 63'd583934381000000000, 63'd631195182000000000
   };

   typedef struct packed {
      bit [62:0] mag;
      bit        post;
   } instant_type;

   typedef struct packed {
      bit [62:0] mag;
      bit        post;
      bit [1:0]  status;
   } conversion_type;

   class conversion_scoreboard;
      conversion_type pending_conversions[$];
      int             errors;
      bit             saturated;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return pending_conversions.size();
      endfunction

      // Signed add of an offset; saturate on its side, flip side across zero.
      function instant_type shift_instant(instant_type a, bit [62:0] d, bit d_pos);
         bit [63:0]   wide;
         instant_type r;
         if (a.post == d_pos) begin
            wide   = {1'b0, a.mag} + {1'b0, d};
            r.post = a.post;
            if (wide[63]) begin
               r.mag     = MagMax;
               saturated = 1'b1;
            end else begin
               r.mag = wide[62:0];
            end
         end else if (d <= a.mag) begin
            r.mag  = a.mag - d;
            r.post = a.post;
         end else begin
            r.mag  = d - a.mag;
            r.post = !a.post;
         end
         if (r.mag == 0) r.post = 1'b1;
         return r;
      endfunction

      // Returns 0 when a pre-epoch count lies beyond the oldest entry.
      function bit leap_offset(instant_type a, bit tai_keyed, output bit [62:0] dat);
         bit        found;
         bit [62:0] lower;
         bit [62:0] upper;
         found = 1'b0;
         dat   = 63'd32 * NsPerSecond;
         if (a.post) begin
            for (int i = 0; i < 5; i++) begin
               lower = tai_keyed ? LeapTaiSteps[i] : LeapUtcSteps[i];
               if (!found && a.mag >= lower) begin
                  dat   = 63'(37 - i) * NsPerSecond;
                  found = 1'b1;
               end
            end
            return 1'b1;
         end
         for (int i = 0; i < 14; i++) begin
            lower = tai_keyed ? LeapTaiPre[i] : LeapUtcPre[i];
            upper = tai_keyed ? LeapTaiPre[i + 1] : LeapUtcPre[i + 1];
            if (!found && lower < a.mag && a.mag <= upper) begin
               dat   = 63'(32 - i) * NsPerSecond;
               found = 1'b1;
            end
         end
         return found;
      endfunction

      function conversion_type convert_instant(bit [62:0] mag, bit after,
                                               bit [3:0] src, bit [3:0] dst);
         conversion_type o;
         instant_type    v;
         bit [62:0]      dat;
         bit             miss;
         o.mag     = '0;
         o.post    = 1'b1;
         o.status  = StatOk;
         saturated = 1'b0;
         miss      = 1'b0;
         if (src > ScaleGps || dst > ScaleGps) begin
            o.status = StatUnsupported;
            return o;
         end
         v.mag  = mag;
         v.post = after || (mag == 0);
         // into TT
         if (src == ScaleUtc) begin
            if (!leap_offset(v, 1'b0, dat)) miss = 1'b1;
            else v = shift_instant(v, dat, 1'b1);
         end else if (src == ScaleGps) begin
            v = shift_instant(v, GpsToTaiNs, 1'b1);
         end
         if (!miss && src != ScaleTt) v = shift_instant(v, TaiToTtNs, 1'b1);
         // out of TT
         if (!miss && dst != ScaleTt) begin
            v = shift_instant(v, TaiToTtNs, 1'b0);
            if (dst == ScaleUtc) begin
               if (!leap_offset(v, 1'b1, dat)) miss = 1'b1;
               else v = shift_instant(v, dat, 1'b0);
            end else if (dst == ScaleGps) begin
               v = shift_instant(v, GpsToTaiNs, 1'b0);
            end
         end
         if (miss) begin
            o.status = StatTableMiss;
         end else begin
            o.mag    = v.mag;
            o.post   = v.post;
            o.status = saturated ? StatOverflow : StatOk;
         end
         return o;
      endfunction

      function void note_request(bit [62:0] mag, bit after, bit [3:0] src, bit [3:0] dst);
         pending_conversions.push_back(convert_instant(mag, after, src, dst));
      endfunction

      function void check_response(logic [62:0] mag, logic after, logic [1:0] status);
         conversion_type o;
         if (pending_conversions.size() == 0) begin
            $display("%0t: unexpected word: magnitude %0d after %0d status %0d",
                     $time, mag, after, status);
            errors++;
            return;
         end
         o = pending_conversions.pop_front();
         if (mag !== o.mag) begin
            $display("%0t: magnitude expected %0d actual %0d", $time, o.mag, mag);
            errors++;
         end
         if (after !== o.post) begin
            $display("%0t: after_epoch expected %0d actual %0d", $time, o.post, after);
            errors++;
         end
         if (status !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, status);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: sim/time_scale_converter_test.sv
// Top of the time scale converter test: clock, reset, bursty request driver,
// patterned response stalls and an idle watchdog.
// Depends on tsc_pkg, conversion_check_pkg and time_scale_converter.
module time_scale_converter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tsc_pkg::*;
   import conversion_check_pkg::*;

   localparam int IdleLimit   = 2000;
   localparam int RandomWords = 750;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [MagW-1:0] req_magnitude_ns = '0;
   logic            req_after_epoch = 1'b0;
   logic [3:0]      req_source_scale = ScaleUtc;
   logic [3:0]      req_target_scale = ScaleUtc;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [MagW-1:0] rsp_result_magnitude_ns;
   logic            rsp_result_after_epoch;
   logic [1:0]      rsp_status;

   conversion_scoreboard board;
   int                   burst_left = 0;
   int                   stall_phase = 0;
   int                   stall_mode = 0;

   time_scale_converter dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_magnitude_ns        (req_magnitude_ns),
      .req_after_epoch         (req_after_epoch),
      .req_source_scale        (req_source_scale),
      .req_target_scale        (req_target_scale),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_result_magnitude_ns (rsp_result_magnitude_ns),
      .rsp_result_after_epoch  (rsp_result_after_epoch),
      .rsp_status              (rsp_status)
   );

   always #6 clock = ~clock;

   // Receiver: switch between always ready, random stalls and a 1-in-4 pattern.
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_phase <= $urandom_range(16, 80);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (stall_phase % 4 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_magnitude_ns, req_after_epoch,
                               req_source_scale, req_target_scale);
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_result_magnitude_ns, rsp_result_after_epoch,
                                 rsp_status);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("time_scale_converter_test: done, errors");
      $finish;
   end

   // Present one word; open a new burst after a random gap when the last one ends.
   task automatic send_word(input logic [MagW-1:0] mag, input logic after,
                            input logic [3:0] src, input logic [3:0] dst);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_magnitude_ns <= mag;
      req_after_epoch  <= after;
      req_source_scale <= src;
      req_target_scale <= dst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [3:0] random_scale();
      return ($urandom_range(0, 19) < 17) ? 4'($urandom_range(0, 3)) : 4'($urandom);
   endfunction

   // Land on or around a leap step, including the offsets that move it into TT.
   function automatic logic [MagW-1:0] near_leap_point();
      logic [MagW-1:0] point;
      logic [MagW-1:0] delta;
      case ($urandom_range(0, 3))
         0: point = LeapUtcSteps[$urandom_range(0, 4)];
         1: point = LeapTaiSteps[$urandom_range(0, 4)];
         2: point = LeapUtcPre[$urandom_range(0, 14)];
         default: point = LeapTaiPre[$urandom_range(0, 14)];
      endcase
      case ($urandom_range(0, 5))
         0: delta = '0;
         1: delta = 63'd1;
         2: delta = TaiToTtNs;
         3: delta = TaiToTtNs + GpsToTaiNs;
         4: delta = 63'($urandom_range(0, 40)) * NsPerSecond;
         default: delta = 63'($urandom) * 16;
      endcase
      if ($urandom_range(0, 1)) return point + delta;
      if (delta > point) return delta - point;
      return point - delta;
   endfunction

   function automatic logic [MagW-1:0] random_magnitude();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: return wide[MagW-1:0];
         3, 4, 5: return near_leap_point();
         6: return 63'($urandom) * 16;
         7: return MagMax - 63'($urandom) * 16;
         default: return 63'(wide % 64'd700000000000000000);
      endcase
   endfunction

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_word('0, 1'b0, ScaleUtc, ScaleUtc);
      send_word('0, 1'b1, ScaleTt, ScaleTai);
      send_word(MagMax, 1'b1, ScaleUtc, ScaleTt);
      send_word(MagMax, 1'b0, ScaleTt, ScaleGps);
      send_word(MagMax, 1'b0, ScaleUtc, ScaleTt);
      send_word(63'd631195200000000000, 1'b0, ScaleUtc, ScaleTai);
      send_word(63'd631195200000000001, 1'b0, ScaleUtc, ScaleTt);
      send_word(63'd536500800000000000, 1'b1, ScaleUtc, ScaleUtc);
      send_word(63'd536500799999999999, 1'b1, ScaleUtc, ScaleTai);
      send_word(63'd189345599999999999, 1'b1, ScaleUtc, ScaleGps);
      send_word(TaiToTtNs, 1'b0, ScaleTai, ScaleTt);
      send_word(GpsToTaiNs, 1'b0, ScaleGps, ScaleTai);
      send_word(63'd1, 1'b1, ScaleTt, ScaleTai);
      send_word(63'd631195150000000000, 1'b0, ScaleTt, ScaleUtc);
      send_word(63'd536500836000000000, 1'b1, ScaleTai, ScaleUtc);
      send_word(63'd31579169000000000, 1'b0, ScaleTai, ScaleUtc);
      send_word(MagMax - 63'd5, 1'b1, ScaleGps, ScaleUtc);
      send_word(63'd123456789, 1'b0, ScaleTt, ScaleTt);
      send_word(63'd400000000000000000, 1'b1, ScaleTai, ScaleGps);
      send_word(NsPerSecond, 1'b0, ScaleGps, ScaleTt);
      send_word(63'd7, 1'b1, ScaleTai, ScaleTai);
      send_word(63'd19000000000, 1'b1, ScaleGps, ScaleGps);
      send_word(MagMax, 1'b1, ScaleFirstUnused, ScaleUtc);
      send_word(63'd5, 1'b0, ScaleUtc, ScaleLastCode);
      send_word(MagMax, 1'b0, ScaleLastCode, ScaleLastCode);

      for (int n = 0; n < RandomWords; n++) begin
         // hold off until the pipe is empty once in mid-run
         if (n == RandomWords / 2) drain_all();
         send_word(random_magnitude(), 1'($urandom), random_scale(), random_scale());
      end

      // let the last accepted word reach the scoreboard before waiting on it
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (board.errors == 0) begin
         $display("time_scale_converter_test: done, clean");
      end else begin
         $display("time_scale_converter_test: done, errors");
      end
      $finish;
   end

endmodule
